FILE: hw/rtl/ascending_integer_sorter_top_assert.svh
// Assertion macros for the sorter checker.
// Both forms sample on the rising edge of clk and are off while rst is high.
`ifndef ASCENDING_INTEGER_SORTER_TOP_ASSERT_SVH
`define ASCENDING_INTEGER_SORTER_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define AIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define AIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ais_pkg.sv
package ais_pkg;

  // Default store capacity and element width
  localparam int MAX_ITEMS_DEF = 32;
  localparam int DATA_W        = 32;

  // Load elements into the chain, then drain the sorted list
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the broadcast word into the chain
    logic shift;   // move every cell one place toward the head
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/ais_cell.sv
// One slot of the insertion chain. Holds one element; cells toward the
// head hold smaller values.
module ais_cell (
  input  logic                              clk,
  input  ais_pkg::cell_ctrl_t               ctrl,
  input  logic                              occupied,
  input  logic signed [ais_pkg::DATA_W-1:0] ins_val,
  input  logic signed [ais_pkg::DATA_W-1:0] prev_val,
  input  logic                              prev_lt,
  input  logic signed [ais_pkg::DATA_W-1:0] next_val,
  output logic signed [ais_pkg::DATA_W-1:0] val,
  output logic                              lt
);

  // Empty slot counts as larger than anything
  assign lt = !occupied || (ins_val < val);

  // Insert: take the word from below if it moved up, else the new word
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (lt) begin
        val <= prev_lt ? prev_val : ins_val;
      end
    end else if (ctrl.shift) begin
      val <= next_val;
    end
  end

endmodule

FILE: hw/rtl/ascending_integer_sorter_top.sv
// Sorter: one element accepted per cycle while loading, placed in the chain
// as it is accepted. After the flagged last word, results follow from the
// next cycle at one per cycle while m_tready is high, drained through the
// head cell; n results for n held words. No input is taken during the drain.
// rst (synchronous, active high) empties the chain and clears overflow.
module ascending_integer_sorter_top #(
  parameter int MAX_ITEMS = ais_pkg::MAX_ITEMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ais_pkg::DATA_W-1:0] s_tdata,   // [31:0] element_value
  input  logic                       s_tlast,   // is_final
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ais_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic                       m_tlast,   // final_result
  output logic [0:0]                 m_tuser    // [0] overflowed
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  ais_pkg::state_t     state, state_next;
  ais_pkg::cell_ctrl_t ctrl;
  logic [CNT_W-1:0]    count;
  logic                ovf;
  logic                in_acc, out_acc, full, last_out;

  logic signed [ais_pkg::DATA_W-1:0] cell_val [MAX_ITEMS];
  logic                              cell_lt  [MAX_ITEMS];

  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;
  assign full     = (count == CNT_W'(MAX_ITEMS));
  assign last_out = (count == CNT_W'(1));

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ais_pkg::ST_LOAD: begin
        if (in_acc && s_tlast) state_next = ais_pkg::ST_DRAIN;
      end
      ais_pkg::ST_DRAIN: begin
        if (out_acc && last_out) state_next = ais_pkg::ST_LOAD;
      end
      default: state_next = ais_pkg::ST_LOAD;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ais_pkg::ST_LOAD:  s_tready = 1'b1;
      ais_pkg::ST_DRAIN: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  // State, fill count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ais_pkg::ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.insert) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.shift) begin
        count <= count - CNT_W'(1);
      end
      if (in_acc && full) begin
        ovf <= 1'b1;
      end else if (out_acc && last_out) begin
        ovf <= 1'b0;
      end
    end
  end

  // Insertion chain, head cell holds the smallest word
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [ais_pkg::DATA_W-1:0] prev_val, next_val;
    logic                              prev_lt;

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_lt  = 1'b0;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_lt  = cell_lt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end

    ais_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (CNT_W'(i) < count),
      .ins_val  ($signed(s_tdata)),
      .prev_val (prev_val),
      .prev_lt  (prev_lt),
      .next_val (next_val),
      .val      (cell_val[i]),
      .lt       (cell_lt[i])
    );
  end

  // Result word comes straight from the head cell
  assign m_tdata    = $unsigned(cell_val[0]);
  assign m_tlast    = last_out;
  assign m_tuser[0] = ovf;

endmodule

FILE: hw/rtl/ais_checker.sv
`include "ascending_integer_sorter_top_assert.svh"

// Port-level checks on the sorter
module ais_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       s_tlast,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [ais_pkg::DATA_W-1:0] m_tdata,
  input logic                       m_tlast,
  input logic [0:0]                 m_tuser
);

  // No input word is taken while results are pending
  `AIS_ASSERT_NOW(a_no_load_in_drain, s_tvalid && s_tready, !m_tvalid, "input taken during drain")

  // A final input word starts the drain on the next cycle
  `AIS_ASSERT_NEXT(a_drain_follows_final, s_tvalid && s_tready && s_tlast, m_tvalid, "no results after final word")

  // Drain ends right after the last result is taken
  `AIS_ASSERT_NEXT(a_drain_ends, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready, "drain did not end")

  // Overflow flag holds across the results of one list
  `AIS_ASSERT_NEXT(a_ovf_steady, m_tvalid && m_tready && !m_tlast, m_tvalid && $stable(m_tuser), "overflow flag changed mid-list")

  // Stalled result word holds
  `AIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind ascending_integer_sorter_top ais_checker u_ais_checker (.*);
